@@ sv/set_assoc_cache_tag_controller_top_defines.svh @@
// assertion macros used by the checker file
`ifndef SET_ASSOC_CACHE_TAG_CONTROLLER_TOP_DEFINES_SVH
`define SET_ASSOC_CACHE_TAG_CONTROLLER_TOP_DEFINES_SVH

// implication checked at every clock edge outside reset
`define SACT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("sact check failed");

// implication checked in the cycle after the antecedent
`define SACT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("sact check failed");

`endif

@@ sv/sact_pkg.sv @@
package sact_pkg;

  localparam int unsigned Sets = 64;
  localparam int unsigned Ways = 4;
  localparam int unsigned LineBytes = 64;

  localparam int unsigned AddrW = 64;
  localparam int unsigned CountW = 4;
  localparam int unsigned OffsW = 6;
  localparam int unsigned WayOutW = 2;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 2;

  localparam logic [CfgIdxW-1:0] CfgEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRepl = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgWback = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgWalloc = 2'd3;

  localparam logic [1:0] ReplLru = 2'd0;
  localparam logic [1:0] ReplFifo = 2'd1;
  localparam logic [1:0] ReplRand = 2'd2;

  localparam logic [15:0] LfsrSeed = 16'hACE1;

  typedef struct packed {
    logic       enabled;
    logic [1:0] repl;
    logic       wback;
    logic       walloc;
  } cfg_t;

  typedef struct packed {
    logic                bypassed;
    logic                hit;
    logic [WayOutW-1:0]  way;
    logic                wb_needed;
    logic [AddrW-1:0]    wb_addr;
    logic                fill_needed;
    logic [AddrW-1:0]    fill_addr;
    logic                mem_wt;
    logic [OffsW-1:0]    offset;
    logic [CountW-1:0]   count;
  } result_t;

endpackage

@@ sv/set_assoc_cache_tag_controller_top.sv @@
// an item passes through the queue, the tag read and the lookup/update before its result
// the back end takes one access at a time and accepts the next after the result is taken
// bypassed items skip the lookup/update in the back end
// reset clears valid/dirty bits, config to defaults and lfsr to its seed
// tag and rank memories are not cleared; there is no clearing pass
module set_assoc_cache_tag_controller_top #(
  parameter int unsigned MAX_ACCESS_BYTES = 8
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // cmd
  input  logic         s_axis_tuser,
  // address[63:0], access_bytes[67:64], zero fill to 72
  input  logic [71:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // bypassed, hit, way[3:2], wb_needed, wb_addr[68:5], fill_needed,
  // fill_addr[133:70], mem_wt, line_offset[140:135], byte_count[144:141]
  output logic [151:0] m_axis_tdata,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [1:0]   cfg_data_i
);
  sact_pkg::cfg_t cfg_q;
  sact_pkg::result_t res;
  logic qv, qr, qcmd, qzero;
  logic [63:0] qaddr;
  logic [5:0] qoff;
  logic [3:0] qcnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{enabled: 1'b1, repl: sact_pkg::ReplLru, wback: 1'b1, walloc: 1'b1};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sact_pkg::CfgEnable: cfg_q.enabled <= cfg_data_i[0];
        sact_pkg::CfgRepl: cfg_q.repl <= cfg_data_i;
        sact_pkg::CfgWback: cfg_q.wback <= cfg_data_i[0];
        sact_pkg::CfgWalloc: cfg_q.walloc <= cfg_data_i[0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  sact_front #(.MaxAccessBytes(MAX_ACCESS_BYTES)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .cmd_i(s_axis_tuser), .addr_i(s_axis_tdata[63:0]), .bytes_i(s_axis_tdata[67:64]),
    .q_valid_o(qv), .q_ready_i(qr), .q_cmd_o(qcmd), .q_addr_o(qaddr),
    .q_zero_o(qzero), .q_offset_o(qoff), .q_count_o(qcnt)
  );

  sact_back u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q),
    .q_valid_i(qv), .q_ready_o(qr), .q_cmd_i(qcmd), .q_addr_i(qaddr),
    .q_zero_i(qzero), .q_offset_i(qoff), .q_count_i(qcnt),
    .res_valid_o(m_axis_tvalid), .res_ready_i(m_axis_tready), .res_o(res)
  );

  assign m_axis_tdata = {7'd0, res.count, res.offset, res.mem_wt, res.fill_addr,
                         res.fill_needed, res.wb_addr, res.wb_needed, res.way,
                         res.hit, res.bypassed};
endmodule

@@ sv/sact_front.sv @@
// accepts items, splits the address and clips the count
module sact_front #(
  parameter int unsigned MaxAccessBytes = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          cmd_i,
  input  logic [sact_pkg::AddrW-1:0]    addr_i,
  input  logic [sact_pkg::CountW-1:0]   bytes_i,
  output logic                          q_valid_o,
  input  logic                          q_ready_i,
  output logic                          q_cmd_o,
  output logic [sact_pkg::AddrW-1:0]    q_addr_o,
  output logic                          q_zero_o,
  output logic [sact_pkg::OffsW-1:0]    q_offset_o,
  output logic [sact_pkg::CountW-1:0]   q_count_o
);
  localparam int unsigned LineBytes = sact_pkg::LineBytes;
  localparam int unsigned OffW = $clog2(LineBytes);
  localparam int unsigned Depth = 2;

  logic [Depth-1:0] v_q, v_d;
  logic [Depth-1:0] cmd_q;
  logic [Depth-1:0] zero_q;
  logic [sact_pkg::AddrW-1:0] addr_q [Depth];
  logic [sact_pkg::OffsW-1:0] offs_q [Depth];
  logic [sact_pkg::CountW-1:0] cnt_q [Depth];
  logic wp_q, wp_d, rp_q, rp_d;

  logic [OffW-1:0] off;
  logic [sact_pkg::CountW-1:0] req;
  logic [OffW:0] room;
  logic [sact_pkg::CountW-1:0] cnt;
  logic push, pop;

  always_comb begin
    off = addr_i[OffW-1:0];
    req = (bytes_i > sact_pkg::CountW'(MaxAccessBytes)) ?
          sact_pkg::CountW'(MaxAccessBytes) : bytes_i;
    room = (OffW+1)'(LineBytes) - {1'b0, off};
    cnt = ({{(OffW+1){1'b0}}, req} > {{sact_pkg::CountW{1'b0}}, room}) ?
          sact_pkg::CountW'(room) : req;
  end

  assign in_ready_o = !v_q[wp_q];
  assign push = in_valid_i && in_ready_o;
  assign q_valid_o = v_q[rp_q];
  assign pop = q_valid_o && q_ready_i;
  assign q_cmd_o = cmd_q[rp_q];
  assign q_addr_o = addr_q[rp_q];
  assign q_zero_o = zero_q[rp_q];
  assign q_offset_o = offs_q[rp_q];
  assign q_count_o = cnt_q[rp_q];

  always_comb begin
    v_d = v_q;
    wp_d = wp_q;
    rp_d = rp_q;
    if (pop) begin
      v_d[rp_q] = 1'b0;
      rp_d = !rp_q;
    end
    if (push) begin
      v_d[wp_q] = 1'b1;
      wp_d = !wp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
      wp_q <= 1'b0;
      rp_q <= 1'b0;
    end else begin
      v_q <= v_d;
      wp_q <= wp_d;
      rp_q <= rp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wp_q] <= cmd_i;
      zero_q[wp_q] <= (req == '0);
      addr_q[wp_q] <= addr_i;
      offs_q[wp_q] <= sact_pkg::OffsW'(off);
      cnt_q[wp_q] <= cnt;
    end
  end
endmodule

@@ sv/sact_back.sv @@
// tag lookup, victim choice and state update, one access at a time
module sact_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  sact_pkg::cfg_t                cfg_i,
  input  logic                          q_valid_i,
  output logic                          q_ready_o,
  input  logic                          q_cmd_i,
  input  logic [sact_pkg::AddrW-1:0]    q_addr_i,
  input  logic                          q_zero_i,
  input  logic [sact_pkg::OffsW-1:0]    q_offset_i,
  input  logic [sact_pkg::CountW-1:0]   q_count_i,
  output logic                          res_valid_o,
  input  logic                          res_ready_i,
  output sact_pkg::result_t             res_o
);
  localparam int unsigned Sets = sact_pkg::Sets;
  localparam int unsigned Ways = sact_pkg::Ways;
  localparam int unsigned OffW = $clog2(sact_pkg::LineBytes);
  localparam int unsigned SetW = $clog2(Sets);
  localparam int unsigned WayW = $clog2(Ways);
  localparam int unsigned TagW = sact_pkg::AddrW - OffW - SetW;
  localparam int unsigned Ent = Sets * Ways;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StLook = 2'd1;
  localparam logic [1:0] StOut = 2'd2;

  logic [1:0] st_q, st_d;
  logic [Ent-1:0] valid_q, dirty_q;
  logic [TagW-1:0] tag_mem [Sets][Ways];
  logic [WayW-1:0] rr_mem [Sets][Ways];
  logic [WayW-1:0] fr_mem [Sets][Ways];
  logic [TagW-1:0] rtag [Ways];
  logic [WayW-1:0] rrr [Ways];
  logic [WayW-1:0] rfr [Ways];
  logic [15:0] lfsr_q;

  logic cmd_q, zero_q;
  logic [sact_pkg::AddrW-1:0] addr_q;
  sact_pkg::result_t res_q;
  logic [SetW-1:0] set;
  logic [TagW-1:0] tag;

  assign set = addr_q[OffW +: SetW];
  assign tag = addr_q[sact_pkg::AddrW-1 -: TagW];
  assign q_ready_o = (st_q == StIdle);
  assign res_valid_o = (st_q == StOut);
  assign res_o = res_q;

  // combinational decision from registered set reads
  logic hit, any_inv, vwas, vdirty;
  logic [WayW-1:0] hw, iw, lw, fw, vw, sel;
  logic [15:0] lfsr_n;
  logic [Ways-1:0] vset;
  always_comb begin
    hit = 1'b0; hw = '0; any_inv = 1'b0; iw = '0; lw = '0; fw = '0;
    for (int i = 0; i < Ways; i++) vset[i] = valid_q[{set, WayW'(i)}];
    for (int i = Ways-1; i >= 0; i--) begin
      if (vset[i] && rtag[i] == tag) begin hit = 1'b1; hw = WayW'(i); end
      if (!vset[i]) begin any_inv = 1'b1; iw = WayW'(i); end
    end
    for (int i = 1; i < Ways; i++) begin
      if (rrr[i] < rrr[lw]) lw = WayW'(i);
      if (rfr[i] < rfr[fw]) fw = WayW'(i);
    end
    lfsr_n = {lfsr_q[0] ^ lfsr_q[2] ^ lfsr_q[3] ^ lfsr_q[5], lfsr_q[15:1]};
    if (any_inv) vw = iw;
    else if (cfg_i.repl == sact_pkg::ReplRand) vw = lfsr_n[WayW-1:0];
    else if (cfg_i.repl == sact_pkg::ReplFifo) vw = fw;
    else vw = lw;
    vwas = vset[vw];
    vdirty = dirty_q[{set, vw}];
    sel = hw;
  end

  logic do_fill, do_hit, wmiss_na;
  assign do_hit = !zero_q && hit;
  assign wmiss_na = !zero_q && !hit && cmd_q && !cfg_i.walloc;
  assign do_fill = !zero_q && !hit && !wmiss_na;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StIdle: if (q_valid_i) st_d = cfg_i.enabled ? StLook : StOut;
      StLook: st_d = StOut;
      StOut: if (res_ready_i) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      valid_q <= '0;
      dirty_q <= '0;
      lfsr_q <= sact_pkg::LfsrSeed;
    end else begin
      st_q <= st_d;
      if (st_q == StLook) begin
        if (do_hit && cmd_q && cfg_i.wback) dirty_q[{set, hw}] <= 1'b1;
        if (do_fill) begin
          valid_q[{set, vw}] <= 1'b1;
          dirty_q[{set, vw}] <= cmd_q && cfg_i.wback;
          if (!any_inv && cfg_i.repl == sact_pkg::ReplRand) lfsr_q <= lfsr_n;
        end
      end
    end
  end

  // payload, memories and result register
  always_ff @(posedge clk_i) begin
    if (st_q == StIdle && q_valid_i) begin
      cmd_q <= q_cmd_i;
      addr_q <= q_addr_i;
      zero_q <= q_zero_i && q_cmd_i;
      res_q <= '{bypassed: !cfg_i.enabled,
                 offset: cfg_i.enabled ? q_offset_i : '0,
                 count: cfg_i.enabled ? q_count_i : '0,
                 default: '0};
      for (int i = 0; i < Ways; i++) begin
        rtag[i] <= tag_mem[q_addr_i[OffW +: SetW]][i];
        rrr[i] <= rr_mem[q_addr_i[OffW +: SetW]][i];
        rfr[i] <= fr_mem[q_addr_i[OffW +: SetW]][i];
      end
    end
    if (st_q == StLook) begin
      if (do_hit) begin
        res_q.hit <= 1'b1;
        res_q.way <= sact_pkg::WayOutW'(sel);
        res_q.mem_wt <= cmd_q && !cfg_i.wback;
        for (int i = 0; i < Ways; i++)
          if (i != hw && vset[i] && rrr[i] > rrr[hw])
            rr_mem[set][i] <= rrr[i] - 1'b1;
        rr_mem[set][hw] <= WayW'($countones(vset) - 1);
      end
      if (wmiss_na) res_q.mem_wt <= 1'b1;
      if (do_fill) begin
        res_q.way <= sact_pkg::WayOutW'(vw);
        res_q.fill_needed <= 1'b1;
        res_q.fill_addr <= {addr_q[sact_pkg::AddrW-1:OffW], {OffW{1'b0}}};
        res_q.mem_wt <= cmd_q && !cfg_i.wback;
        if (vwas && vdirty) begin
          res_q.wb_needed <= 1'b1;
          res_q.wb_addr <= {rtag[vw], set, {OffW{1'b0}}};
        end
        for (int i = 0; i < Ways; i++) begin
          if (i != vw && vset[i] && vwas) begin
            if (rrr[i] > rrr[vw]) rr_mem[set][i] <= rrr[i] - 1'b1;
            if (rfr[i] > rfr[vw]) fr_mem[set][i] <= rfr[i] - 1'b1;
          end
        end
        rr_mem[set][vw] <= WayW'($countones(vset) - (vwas ? 1 : 0));
        fr_mem[set][vw] <= WayW'($countones(vset) - (vwas ? 1 : 0));
        tag_mem[set][vw] <= tag;
      end
    end
  end
endmodule

@@ sv/sact_checker.sv @@
`include "set_assoc_cache_tag_controller_top_defines.svh"
module sact_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [151:0] m_axis_tdata
);
  `SACT_ASSERT_IMP(a_bypass_quiet, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[0], m_axis_tdata[151:1] == '0)
  `SACT_ASSERT_IMP(a_hit_no_fill, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[1], !m_axis_tdata[69] && !m_axis_tdata[4])
  `SACT_ASSERT_IMP(a_wb_has_fill, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[4], m_axis_tdata[69])
  `SACT_ASSERT_NXT(a_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
endmodule

bind set_assoc_cache_tag_controller_top sact_checker u_sact_checker (
  .clk_i, .rst_ni, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
);
